[sv/dwhs_pkg.sv]
package dwhs_pkg;

    // Wrapper format codes held in the configuration register.
    localparam logic [1:0] FMT_ZLIB    = 2'd0;
    localparam logic [1:0] FMT_GZIP    = 2'd1;
    localparam logic [1:0] FMT_RAW     = 2'd2;
    localparam logic [1:0] FMT_UNSUPP  = 2'd3;

    // Parser phases.
    localparam logic [1:0] PH_FIXED    = 2'd0;
    localparam logic [1:0] PH_FNAME    = 2'd1;
    localparam logic [1:0] PH_DONE     = 2'd2;
    localparam logic [1:0] PH_ERROR    = 2'd3;

    // Byte classes on the result side.
    localparam logic [1:0] CLS_HEADER  = 2'd0;
    localparam logic [1:0] CLS_PAYLOAD = 2'd1;
    localparam logic [1:0] CLS_ERROR   = 2'd2;

    // Header lengths and gzip fixed-header fields.
    localparam logic [3:0] ZLIB_LEN    = 4'd2;
    localparam logic [3:0] GZIP_LEN    = 4'd10;
    localparam logic [3:0] POS_ID1     = 4'd0;
    localparam logic [3:0] POS_ID2     = 4'd1;
    localparam logic [3:0] POS_CM      = 4'd2;
    localparam logic [3:0] POS_FLG     = 4'd3;
    localparam logic [7:0] GZ_ID1      = 8'h1F;
    localparam logic [7:0] GZ_ID2      = 8'h8B;
    localparam logic [7:0] GZ_CM       = 8'h08;
    localparam logic [7:0] GZ_FHCRC    = 8'h02;
    localparam logic [7:0] GZ_FEXTRA   = 8'h04;
    localparam logic [7:0] GZ_FNAME    = 8'h08;
    localparam logic [7:0] GZ_FCOMMENT = 8'h10;
    localparam logic [7:0] GZ_RESERVED = 8'hE0;
    localparam logic [7:0] GZ_REJECT   = GZ_FHCRC | GZ_FEXTRA | GZ_FCOMMENT | GZ_RESERVED;

    // Result queue geometry.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One classified word travelling from the front end to the result queue.
    typedef struct packed {
        logic [7:0] byte_out;
        logic [1:0] byte_class;
        logic       header_complete;
    } t_result;

endpackage

[sv/dwhs_front.sv]
module dwhs_front import dwhs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_restart,
    output t_result    o_result
);

    logic [1:0] r_format;
    logic [1:0] r_phase,   n_phase;
    logic [3:0] r_count,   n_count;
    logic       r_magic,   n_magic;
    logic [7:0] r_flag,    n_flag;

    logic [1:0] c_phase;
    logic [3:0] c_count;
    logic       c_magic;
    logic [7:0] c_flag;
    logic [3:0] inc_count;
    logic [1:0] cls;
    logic       done;

    // A restart clears the stream state before the word is classified.
    always_comb begin
        c_phase = i_restart ? PH_FIXED : r_phase;
        c_count = i_restart ? 4'd0     : r_count;
        c_magic = i_restart ? 1'b0     : r_magic;
        c_flag  = i_restart ? 8'd0     : r_flag;
    end

    assign inc_count = c_count + 4'd1;

    // Classification and next-state logic for one word.
    always_comb begin
        n_phase = c_phase;
        n_count = c_count;
        n_magic = c_magic;
        n_flag  = c_flag;
        cls     = CLS_HEADER;
        done    = 1'b0;
        unique case (c_phase)
            PH_ERROR: begin
                cls = CLS_ERROR;
            end
            PH_DONE: begin
                cls = CLS_PAYLOAD;
            end
            PH_FNAME: begin
                if (i_data_byte == 8'd0) begin
                    n_phase = PH_DONE;
                    done    = 1'b1;
                end
            end
            default: begin
                case (r_format)
                    FMT_ZLIB: begin
                        n_count = inc_count;
                        if (inc_count >= ZLIB_LEN) begin
                            n_count = 4'd0;
                            n_phase = PH_DONE;
                            done    = 1'b1;
                        end
                    end
                    FMT_GZIP: begin
                        if ((c_count == POS_ID1 && i_data_byte != GZ_ID1) ||
                            (c_count == POS_ID2 && i_data_byte != GZ_ID2) ||
                            (c_count == POS_CM  && i_data_byte != GZ_CM)) begin
                            n_magic = 1'b1;
                        end
                        if (c_count == POS_FLG) begin
                            n_flag = i_data_byte;
                        end
                        n_count = inc_count;
                        if (inc_count >= GZIP_LEN) begin
                            n_count = 4'd0;
                            if (n_magic || (n_flag & GZ_REJECT) != 8'd0) begin
                                n_phase = PH_ERROR;
                                cls     = CLS_ERROR;
                            end else if ((n_flag & GZ_FNAME) != 8'd0) begin
                                n_phase = PH_FNAME;
                            end else begin
                                n_phase = PH_DONE;
                                done    = 1'b1;
                            end
                        end
                    end
                    FMT_RAW: begin
                        n_phase = PH_DONE;
                        cls     = CLS_PAYLOAD;
                    end
                    default: begin
                        n_phase = PH_ERROR;
                        cls     = CLS_ERROR;
                    end
                endcase
            end
        endcase
    end

    // Result word handed to the queue.
    always_comb begin
        o_result.byte_out        = i_data_byte;
        o_result.byte_class      = cls;
        o_result.header_complete = done;
    end

    // Format register; writes never touch the stream state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_ZLIB;
        end else if (i_cfg_we) begin
            r_format <= i_cfg_wdata;
        end
    end

    // Stream state advances on every accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIXED;
            r_count <= 4'd0;
            r_magic <= 1'b0;
            r_flag  <= 8'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_magic <= n_magic;
            r_flag  <= n_flag;
        end
    end

endmodule

[sv/dwhs_fifo.sv]
module dwhs_fifo import dwhs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr_en,
    input  t_result i_wr_data,
    input  logic    i_rd_en,
    output t_result o_rd_data,
    output logic    o_full,
    output logic    o_empty
);

    t_result              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic [Q_CNT_W-1:0]   n_count;

    assign o_full    = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    // Occupancy follows the two handshakes.
    always_comb begin
        n_count = r_count;
        if (i_wr_en && !i_rd_en) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (!i_wr_en && i_rd_en) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_rd_en) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

[sv/deflate_wrapper_header_skipper_core.sv]
// A pushed word is registered in the result queue memory and read combinationally at its head.
// Throughput: one word per cycle while the queue is not full; the front end classifies each word
// in the cycle it is taken, and a four-entry result queue absorbs stalls on the pop side.
// Reset: synchronous, active low; the format returns to zlib, the parser to the
// start of the fixed header, and the result queue empties.
module deflate_wrapper_header_skipper_core import dwhs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_data_byte,
    input  logic       i_restart,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_byte_out,
    output logic [1:0] o_byte_class,
    output logic       o_header_complete
);

    logic    push_ok;
    logic    pop_ok;
    t_result front_result;
    t_result queue_result;

    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    // Front end: format register, parser state and classification.
    dwhs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (push_ok),
        .i_data_byte (i_data_byte),
        .i_restart   (i_restart),
        .o_result    (front_result)
    );

    // Back end: result queue toward the consumer.
    dwhs_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (push_ok),
        .i_wr_data (front_result),
        .i_rd_en   (pop_ok),
        .o_rd_data (queue_result),
        .o_full    (o_full),
        .o_empty   (o_empty)
    );

    assign o_byte_out        = queue_result.byte_out;
    assign o_byte_class      = queue_result.byte_class;
    assign o_header_complete = queue_result.header_complete;

    // After an accepted word the result queue is not empty at the next edge.
    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_ok |=> !o_empty)
        else $error("accepted word did not reach the result queue");

    // The queue is never full and empty at once.
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_full && o_empty))
        else $error("queue reports full and empty together");

    // Header completion only marks a stripped header word.
    a_done_is_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_header_complete) |-> (o_byte_class == CLS_HEADER))
        else $error("header completion on a non-header word");

    // No class code beyond the error class is ever produced.
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_byte_class == CLS_HEADER || o_byte_class == CLS_PAYLOAD ||
                      o_byte_class == CLS_ERROR))
        else $error("undefined byte class");

endmodule

[tb/deflate_wrapper_header_skipper_core_tb.sv]
`timescale 1ns / 1ps

module deflate_wrapper_header_skipper_core_tb import dwhs_pkg::*;;

    localparam int RANDOM_BYTES = 1000;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int QUIET_FROM   = 600;
    localparam int QUIET_TO     = 1000;

    // One pending stimulus entry: either a format write or a stream byte.
    typedef struct {
        logic       is_cfg;
        logic [1:0] fmt;
        logic [7:0] data;
        logic       restart;
    } t_stim;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_wdata = FMT_ZLIB;
    logic       i_push = 1'b0;
    logic       o_full;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_restart = 1'b0;
    logic       i_pop = 1'b0;
    logic       o_empty;
    logic [7:0] o_byte_out;
    logic [1:0] o_byte_class;
    logic       o_header_complete;

    t_stim   pending_stim [$];
    t_result predicted_words [256];
    int      words_sent = 0;
    int      words_checked = 0;
    int      bytes_queued = 0;
    int      error_cnt = 0;
    int      cycle_cnt = 0;

    // Shadow copy of the parser state and the format register.
    logic [1:0] fmt_reg = FMT_ZLIB;
    logic [1:0] sh_phase = PH_FIXED;
    logic [3:0] sh_count = 4'd0;
    logic       sh_magic_bad = 1'b0;
    logic [7:0] sh_flags = 8'h00;

    deflate_wrapper_header_skipper_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_push            (i_push),
        .o_full            (o_full),
        .i_data_byte       (i_data_byte),
        .i_restart         (i_restart),
        .i_pop             (i_pop),
        .o_empty           (o_empty),
        .o_byte_out        (o_byte_out),
        .o_byte_class      (o_byte_class),
        .o_header_complete (o_header_complete)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Random idle decision shared by both sides; a window of cycles has no idling.
    function automatic bit take_break();
        if (cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO) begin
            return 1'b0;
        end
        return $urandom_range(99) < 13;
    endfunction

    // Classify one byte and advance the shadow parser state.
    function automatic t_result classify_byte(input logic [7:0] b, input logic rs);
        t_result r;
        r.byte_out = b;
        r.byte_class = CLS_HEADER;
        r.header_complete = 1'b0;
        if (rs) begin
            sh_phase = PH_FIXED;
            sh_count = 4'd0;
            sh_magic_bad = 1'b0;
            sh_flags = 8'h00;
        end
        case (sh_phase)
            PH_ERROR: begin
                r.byte_class = CLS_ERROR;
            end
            PH_DONE: begin
                r.byte_class = CLS_PAYLOAD;
            end
            PH_FNAME: begin
                // The file name ends at its terminating NUL.
                if (b == 8'h00) begin
                    sh_phase = PH_DONE;
                    r.header_complete = 1'b1;
                end
            end
            default: begin
                case (fmt_reg)
                    FMT_ZLIB: begin
                        sh_count = sh_count + 4'd1;
                        if (sh_count >= ZLIB_LEN) begin
                            sh_count = 4'd0;
                            sh_phase = PH_DONE;
                            r.header_complete = 1'b1;
                        end
                    end
                    FMT_GZIP: begin
                        if (sh_count == POS_ID1 && b != GZ_ID1) sh_magic_bad = 1'b1;
                        if (sh_count == POS_ID2 && b != GZ_ID2) sh_magic_bad = 1'b1;
                        if (sh_count == POS_CM && b != GZ_CM) sh_magic_bad = 1'b1;
                        if (sh_count == POS_FLG) sh_flags = b;
                        sh_count = sh_count + 4'd1;
                        if (sh_count >= GZIP_LEN) begin
                            sh_count = 4'd0;
                            if (sh_magic_bad || (sh_flags & GZ_REJECT) != 8'h00) begin
                                sh_phase = PH_ERROR;
                                r.byte_class = CLS_ERROR;
                            end else if ((sh_flags & GZ_FNAME) != 8'h00) begin
                                sh_phase = PH_FNAME;
                            end else begin
                                sh_phase = PH_DONE;
                                r.header_complete = 1'b1;
                            end
                        end
                    end
                    FMT_RAW: begin
                        sh_phase = PH_DONE;
                        r.byte_class = CLS_PAYLOAD;
                    end
                    default: begin
                        sh_phase = PH_ERROR;
                        r.byte_class = CLS_ERROR;
                    end
                endcase
            end
        endcase
        return r;
    endfunction

    task automatic add_cfg(input logic [1:0] fmt);
        t_stim s;
        s.is_cfg = 1'b1;
        s.fmt = fmt;
        s.data = 8'h00;
        s.restart = 1'b0;
        pending_stim.push_back(s);
    endtask

    task automatic add_byte(input logic [7:0] b, input logic rs);
        t_stim s;
        s.is_cfg = 1'b0;
        s.fmt = FMT_ZLIB;
        s.data = b;
        s.restart = rs;
        pending_stim.push_back(s);
        bytes_queued++;
    endtask

    task automatic add_random_bytes(input int n);
        for (int i = 0; i < n; i++) begin
            add_byte(8'($urandom_range(255)), 1'b0);
        end
    endtask

    // A gzip stream; bad_pos corrupts one magic byte, cut keeps only a header prefix.
    task automatic add_gzip(input logic rs, input logic [7:0] flg, input int bad_pos,
                            input int name_len, input int payload_len, input int cut);
        logic [7:0] hdr [10];
        int         keep;
        keep = (cut > 0) ? cut : 10;
        hdr[0] = GZ_ID1;
        hdr[1] = GZ_ID2;
        hdr[2] = GZ_CM;
        hdr[3] = flg;
        for (int i = 4; i < 10; i++) begin
            hdr[i] = 8'($urandom_range(255));
        end
        if (bad_pos >= 0) begin
            hdr[bad_pos] = hdr[bad_pos] ^ 8'($urandom_range(255, 1));
        end
        for (int i = 0; i < keep; i++) begin
            add_byte(hdr[i], (i == 0) ? rs : 1'b0);
        end
        if (cut == 0) begin
            if ((flg & GZ_FNAME) != 8'h00) begin
                for (int i = 0; i < name_len; i++) begin
                    add_byte(8'($urandom_range(255, 1)), 1'b0);
                end
                add_byte(8'h00, 1'b0);
            end
            add_random_bytes(payload_len);
        end
    endtask

    // One random stream shaped by the current format, or plain noise.
    task automatic add_stream(input logic [1:0] fmt);
        logic       rs;
        int         pick;
        logic [7:0] flg;
        int         bad_pos;
        int         cut;
        rs = ($urandom_range(9) != 0);
        pick = $urandom_range(9);
        if (pick == 0) begin
            for (int i = $urandom_range(8, 1); i > 0; i--) begin
                add_byte(8'($urandom_range(255)), ($urandom_range(7) == 0));
            end
        end else begin
            case (fmt)
                FMT_ZLIB: begin
                    add_byte(8'($urandom_range(255)), rs);
                    add_byte(8'($urandom_range(255)), 1'b0);
                    add_random_bytes($urandom_range(12));
                end
                FMT_GZIP: begin
                    pick = $urandom_range(9);
                    flg = 8'($urandom_range(255));
                    if (pick < 6) begin
                        flg = flg & ~GZ_REJECT;
                    end else if (pick < 8) begin
                        flg = (flg & ~GZ_REJECT) | (GZ_REJECT & (8'h02 << $urandom_range(6)));
                    end
                    bad_pos = ($urandom_range(6) == 0) ? $urandom_range(2) : -1;
                    cut = ($urandom_range(9) == 0) ? $urandom_range(9, 1) : 0;
                    add_gzip(rs, flg, bad_pos, $urandom_range(6), $urandom_range(12), cut);
                end
                FMT_RAW: begin
                    add_byte(8'($urandom_range(255)), rs);
                    add_random_bytes($urandom_range(12));
                end
                default: begin
                    add_byte(8'($urandom_range(255)), rs);
                    add_random_bytes($urandom_range(3));
                end
            endcase
        end
    endtask

    // Driver: format writes only when no word is outstanding, stream bytes otherwise.
    always @(posedge i_clk) begin
        t_result pred;
        t_stim   nxt;
        if (!i_rst_n) begin
            i_push <= 1'b0;
            i_cfg_we <= 1'b0;
            fmt_reg = FMT_ZLIB;
            sh_phase = PH_FIXED;
            sh_count = 4'd0;
            sh_magic_bad = 1'b0;
            sh_flags = 8'h00;
        end else begin
            if (i_cfg_we) begin
                fmt_reg = i_cfg_wdata;
            end
            if (i_push && !o_full) begin
                pred = classify_byte(i_data_byte, i_restart);
                predicted_words[words_sent % 256] = pred;
                words_sent <= words_sent + 1;
            end
            // A word that was not taken stays on the bus unchanged.
            if (!(i_push && o_full)) begin
                if (pending_stim.size() == 0 || take_break()) begin
                    i_push <= 1'b0;
                    i_cfg_we <= 1'b0;
                end else if (pending_stim[0].is_cfg) begin
                    i_push <= 1'b0;
                    if (!i_push && !i_cfg_we && words_sent == words_checked) begin
                        nxt = pending_stim.pop_front();
                        i_cfg_we <= 1'b1;
                        i_cfg_wdata <= nxt.fmt;
                    end else begin
                        i_cfg_we <= 1'b0;
                    end
                end else begin
                    nxt = pending_stim.pop_front();
                    i_push <= 1'b1;
                    i_data_byte <= nxt.data;
                    i_restart <= nxt.restart;
                    i_cfg_we <= 1'b0;
                end
            end
        end
    end

    // Monitor: each popped word is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                if (words_checked == words_sent) begin
                    $error("unexpected word: byte_out %0h byte_class %0d", o_byte_out,
                           o_byte_class);
                    error_cnt++;
                end else begin
                    want = predicted_words[words_checked % 256];
                    if (o_byte_out !== want.byte_out) begin
                        $error("byte_out expected %0h actual %0h", want.byte_out, o_byte_out);
                        error_cnt++;
                    end
                    if (o_byte_class !== want.byte_class) begin
                        $error("byte_class expected %0d actual %0d", want.byte_class,
                               o_byte_class);
                        error_cnt++;
                    end
                    if (o_header_complete !== want.header_complete) begin
                        $error("header_complete expected %0b actual %0b",
                               want.header_complete, o_header_complete);
                        error_cnt++;
                    end
                    words_checked <= words_checked + 1;
                end
            end
            i_pop <= !take_break();
        end
    end

    initial begin
        logic [1:0] fmt;
        int         pick;

        // Directed part: every format, both byte extremes, restart both ways.
        add_cfg(FMT_ZLIB);
        add_byte(8'h78, 1'b1);
        add_byte(8'h9C, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_cfg(FMT_RAW);
        add_byte(8'hFF, 1'b1);
        add_byte(8'h00, 1'b0);
        add_cfg(FMT_UNSUPP);
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b0);
        add_cfg(FMT_GZIP);
        // Gzip with an empty file name, then one payload byte.
        add_gzip(1'b1, GZ_FNAME, -1, 0, 1, 0);
        // Gzip with a rejected flag fails on its tenth byte.
        add_gzip(1'b1, GZ_FCOMMENT, -1, 0, 0, 0);

        // Random part: format phases, each holding a few streams.
        while (bytes_queued < RANDOM_BYTES + 30) begin
            pick = $urandom_range(19);
            fmt = (pick < 8) ? FMT_GZIP : (pick < 13) ? FMT_ZLIB :
                  (pick < 17) ? FMT_RAW : FMT_UNSUPP;
            add_cfg(fmt);
            for (int i = $urandom_range(4, 1); i > 0; i--) begin
                add_stream(fmt);
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every queued byte has come back and been checked.
        while (words_checked != bytes_queued) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (error_cnt == 0 && words_sent == words_checked) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
